// ===== rtl/klex_pkg.sv =====
//------------------------------------------------------------------------------
// Keyword lexer package
// Shared widths, token kinds, keyword table, queue entry types and character
// classification functions.
//------------------------------------------------------------------------------
package klex_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int KEYWORD_CHARS_DEF = 6;

	localparam int CHAR_W      = 8;
	localparam int KIND_W      = 6;
	localparam int START_W     = 32;
	localparam int LENGTH_W    = 16;
	localparam int TDATA_IN_W  = 8;
	localparam int TDATA_OUT_W = 56;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [LENGTH_W-1:0] LENGTH_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_INT     = 6'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd1;
	localparam logic [KIND_W-1:0] KIND_KW_BASE = 6'd2;
	localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd12;
	localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd13;
	localparam logic [KIND_W-1:0] KIND_STAR    = 6'd14;
	localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd15;
	localparam logic [KIND_W-1:0] KIND_EQ      = 6'd16;
	localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd17;
	localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd18;
	localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd19;
	localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd20;
	localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd21;
	localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd22;
	localparam logic [KIND_W-1:0] KIND_LT      = 6'd23;
	localparam logic [KIND_W-1:0] KIND_LE      = 6'd24;
	localparam logic [KIND_W-1:0] KIND_GT      = 6'd25;
	localparam logic [KIND_W-1:0] KIND_GE      = 6'd26;
	localparam logic [KIND_W-1:0] KIND_AMP     = 6'd27;
	localparam logic [KIND_W-1:0] KIND_ANDAND  = 6'd28;
	localparam logic [KIND_W-1:0] KIND_BAR     = 6'd29;
	localparam logic [KIND_W-1:0] KIND_OROR    = 6'd30;
	localparam logic [KIND_W-1:0] KIND_EOF     = 6'd31;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 6'd32;

	localparam int KW_COUNT     = 10;
	localparam int KW_TEXT_BITS = 64;

	localparam logic [KW_TEXT_BITS-1:0] KW_TEXT [KW_COUNT] = '{
		"bool", "double", "else", "false", "if",
		"int", "print", "return", "true", "var"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd4, 4'd6, 4'd4, 4'd5, 4'd2, 4'd3, 4'd5, 4'd6, 4'd4, 4'd3
	};

	typedef enum logic [2:0] {
		PEND_NONE,
		PEND_INT,
		PEND_WORD,
		PEND_EQ,
		PEND_LT,
		PEND_GT,
		PEND_AMP,
		PEND_BAR
	} pend_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [START_W-1:0]  start;
		logic [LENGTH_W-1:0] length;
	} token_t;

	typedef struct packed {
		logic   pair;
		token_t tok_a;
		token_t tok_b;
	} entry_t;

	typedef struct packed {
		logic              hit;
		logic [KIND_W-1:0] kind;
	} op_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic op_t single_op(input logic [CHAR_W-1:0] c);
		op_t r;
		r.hit  = 1'b1;
		r.kind = KIND_ERROR;
		unique case (c)
			"+":     r.kind = KIND_PLUS;
			"-":     r.kind = KIND_MINUS;
			"*":     r.kind = KIND_STAR;
			"/":     r.kind = KIND_SLASH;
			"(":     r.kind = KIND_LPAREN;
			")":     r.kind = KIND_RPAREN;
			"{":     r.kind = KIND_LBRACE;
			"}":     r.kind = KIND_RBRACE;
			",":     r.kind = KIND_COMMA;
			";":     r.kind = KIND_SEMI;
			default: r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/klex_front.sv =====
//------------------------------------------------------------------------------
// Keyword lexer front end
// Accepts characters, classifies them, keeps the pending token and pushes
// any tokens that a character completes, one or two, into the queue.
//------------------------------------------------------------------------------
module klex_front #(
	parameter int POSITION_BITS = klex_pkg::POSITION_BITS_DEF,
	parameter int KEYWORD_CHARS = klex_pkg::KEYWORD_CHARS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [klex_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] char_byte
	input  logic [0:0]                          s_tuser,   // [0] end_of_text
	input  logic                                full,
	output logic                                push,
	output klex_pkg::entry_t                    push_entry
);

	localparam int START_W  = klex_pkg::START_W;
	localparam int LENGTH_W = klex_pkg::LENGTH_W;
	localparam int PREFIX_W = KEYWORD_CHARS * klex_pkg::CHAR_W;

	klex_pkg::pend_t           pend_q, pend_d;
	logic [POSITION_BITS-1:0]  pos_q, pos_d;
	logic [POSITION_BITS-1:0]  origin_q, origin_d;
	logic [LENGTH_W-1:0]       len_q, len_d;
	logic [PREFIX_W-1:0]       prefix_q, prefix_d;
	logic                      fin_q, fin_d;

	logic                          accept;
	logic [klex_pkg::CHAR_W-1:0]   c;
	logic                          eot;
	logic                          pair_hit;
	logic                          cont_hit;
	logic                          flush_hit;
	logic                          new_hit;
	logic [klex_pkg::KIND_W-1:0]   pair_kind;
	logic [klex_pkg::KIND_W-1:0]   word_kind;
	klex_pkg::token_t              tok_flush;
	klex_pkg::token_t              tok_new;
	klex_pkg::op_t                 op;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;
	assign c        = s_tdata[klex_pkg::CHAR_W-1:0];
	assign eot      = s_tuser[0];
	assign op       = klex_pkg::single_op(c);

	assign pair_hit = (c == "=" && (pend_q == klex_pkg::PEND_EQ || pend_q == klex_pkg::PEND_LT ||
			pend_q == klex_pkg::PEND_GT)) ||
		(c == "&" && pend_q == klex_pkg::PEND_AMP) ||
		(c == "|" && pend_q == klex_pkg::PEND_BAR);
	assign cont_hit = (pend_q == klex_pkg::PEND_INT && klex_pkg::is_digit(c)) ||
		(pend_q == klex_pkg::PEND_WORD && klex_pkg::is_alpha(c));

	always_comb begin
		word_kind = klex_pkg::KIND_IDENT;
		for (int i = 0; i < klex_pkg::KW_COUNT; i++) begin
			if (len_q == LENGTH_W'(klex_pkg::KW_LEN[i]) &&
					klex_pkg::KW_TEXT_BITS'(prefix_q) == klex_pkg::KW_TEXT[i]) begin
				word_kind = klex_pkg::KIND_KW_BASE + klex_pkg::KIND_W'(i);
			end
		end
	end

	always_comb begin
		tok_flush.start  = START_W'(origin_q);
		tok_flush.length = LENGTH_W'(1);
		tok_flush.kind   = klex_pkg::KIND_ERROR;
		pair_kind        = klex_pkg::KIND_OROR;
		unique case (pend_q)
			klex_pkg::PEND_INT: begin
				tok_flush.kind   = klex_pkg::KIND_INT;
				tok_flush.length = len_q;
			end
			klex_pkg::PEND_WORD: begin
				tok_flush.kind   = word_kind;
				tok_flush.length = len_q;
			end
			klex_pkg::PEND_EQ: begin
				tok_flush.kind = klex_pkg::KIND_EQ;
				pair_kind      = klex_pkg::KIND_EQ;
			end
			klex_pkg::PEND_LT: begin
				tok_flush.kind = klex_pkg::KIND_LT;
				pair_kind      = klex_pkg::KIND_LE;
			end
			klex_pkg::PEND_GT: begin
				tok_flush.kind = klex_pkg::KIND_GT;
				pair_kind      = klex_pkg::KIND_GE;
			end
			klex_pkg::PEND_AMP: begin
				tok_flush.kind = klex_pkg::KIND_AMP;
				pair_kind      = klex_pkg::KIND_ANDAND;
			end
			klex_pkg::PEND_BAR: begin
				tok_flush.kind = klex_pkg::KIND_BAR;
				pair_kind      = klex_pkg::KIND_OROR;
			end
			default: begin
				tok_flush.kind = klex_pkg::KIND_ERROR;
			end
		endcase
	end

	always_comb begin
		pend_d    = pend_q;
		pos_d     = pos_q;
		origin_d  = origin_q;
		len_d     = len_q;
		prefix_d  = prefix_q;
		fin_d     = fin_q;
		flush_hit = 1'b0;
		new_hit   = 1'b0;
		tok_new.kind   = klex_pkg::KIND_ERROR;
		tok_new.start  = START_W'(pos_q);
		tok_new.length = LENGTH_W'(1);
		if (accept && !fin_q) begin
			if (eot) begin
				flush_hit      = pend_q != klex_pkg::PEND_NONE;
				new_hit        = 1'b1;
				tok_new.kind   = klex_pkg::KIND_EOF;
				tok_new.length = '0;
				pend_d         = klex_pkg::PEND_NONE;
				fin_d          = 1'b1;
			end else if (pair_hit) begin
				new_hit        = 1'b1;
				tok_new.kind   = pair_kind;
				tok_new.start  = START_W'(origin_q);
				tok_new.length = LENGTH_W'(2);
				pend_d         = klex_pkg::PEND_NONE;
				pos_d          = pos_q + POSITION_BITS'(1);
			end else if (cont_hit) begin
				if (pend_q == klex_pkg::PEND_WORD && len_q < LENGTH_W'(KEYWORD_CHARS)) begin
					prefix_d = {prefix_q[PREFIX_W-klex_pkg::CHAR_W-1:0], c};
				end
				if (len_q != klex_pkg::LENGTH_MAX) begin
					len_d = len_q + LENGTH_W'(1);
				end
				pos_d = pos_q + POSITION_BITS'(1);
			end else begin
				flush_hit = pend_q != klex_pkg::PEND_NONE;
				pend_d    = klex_pkg::PEND_NONE;
				pos_d     = pos_q + POSITION_BITS'(1);
				if (klex_pkg::is_space(c)) begin
					new_hit = 1'b0;
				end else if (klex_pkg::is_digit(c) || klex_pkg::is_alpha(c)) begin
					pend_d   = klex_pkg::is_digit(c) ? klex_pkg::PEND_INT : klex_pkg::PEND_WORD;
					origin_d = pos_q;
					len_d    = LENGTH_W'(1);
					prefix_d = PREFIX_W'(c);
				end else if (op.hit) begin
					new_hit      = 1'b1;
					tok_new.kind = op.kind;
				end else if (c == "=" || c == "<" || c == ">" || c == "&" || c == "|") begin
					origin_d = pos_q;
					unique case (c)
						"=":     pend_d = klex_pkg::PEND_EQ;
						"<":     pend_d = klex_pkg::PEND_LT;
						">":     pend_d = klex_pkg::PEND_GT;
						"&":     pend_d = klex_pkg::PEND_AMP;
						default: pend_d = klex_pkg::PEND_BAR;
					endcase
				end else if (c == '0) begin
					new_hit        = 1'b1;
					tok_new.kind   = klex_pkg::KIND_EOF;
					tok_new.length = '0;
					fin_d          = 1'b1;
				end else begin
					new_hit      = 1'b1;
					tok_new.kind = klex_pkg::KIND_ERROR;
					fin_d        = 1'b1;
				end
			end
		end
	end

	assign push             = flush_hit || new_hit;
	assign push_entry.pair  = flush_hit && new_hit;
	assign push_entry.tok_a = flush_hit ? tok_flush : tok_new;
	assign push_entry.tok_b = tok_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= klex_pkg::PEND_NONE;
			pos_q    <= '0;
			origin_q <= '0;
			len_q    <= '0;
			prefix_q <= '0;
			fin_q    <= 1'b0;
		end else begin
			pend_q   <= pend_d;
			pos_q    <= pos_d;
			origin_q <= origin_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
			fin_q    <= fin_d;
		end
	end

`ifndef ASSERT_OFF
	a_no_push_when_finished: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> !push) else $error("token pushed after end of text or error");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("token pushed into a full queue");
	a_eot_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !fin_q && eot) |=> fin_q) else $error("end flag did not stop the lexer");
`endif

endmodule

// ===== rtl/klex_queue.sv =====
//------------------------------------------------------------------------------
// Keyword lexer token queue
// Short first-in first-out buffer of token entries between front and back.
//------------------------------------------------------------------------------
module klex_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  klex_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output klex_pkg::entry_t head,
	output logic             empty
);

	localparam int DEPTH = klex_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	klex_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_q;
	logic [PTR_W-1:0]  rd_q;
	logic [CNT_W-1:0]  count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/klex_back.sv =====
//------------------------------------------------------------------------------
// Keyword lexer back end
// Takes queue entries and sends their tokens one per transaction through an
// output register.
//------------------------------------------------------------------------------
module klex_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  klex_pkg::entry_t                     head,
	input  logic                                 empty,
	output logic                                 pop,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [klex_pkg::TDATA_OUT_W-1:0]     m_tdata,   // token_kind, token_start, token_length
	output logic                                 m_tlast
);

	localparam int PAD_W = klex_pkg::TDATA_OUT_W - klex_pkg::KIND_W - klex_pkg::START_W -
		klex_pkg::LENGTH_W;

	logic             valid_q;
	logic             sel_q;
	logic             last_q;
	klex_pkg::token_t tok_q;
	klex_pkg::token_t tok;
	logic             load;
	logic             last;

	assign load = !empty && (!valid_q || m_tready);
	assign tok  = sel_q ? head.tok_b : head.tok_a;
	assign last = sel_q || !head.pair;
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !last;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= tok;
			last_q <= last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{PAD_W{1'b0}}, tok_q.length, tok_q.start, tok_q.kind};

endmodule

// ===== rtl/keyword_lexer.sv =====
//------------------------------------------------------------------------------
// Keyword lexer
// Streaming maximal-munch lexer: characters in, tokens of kind, start and
// length out, with a token queue between the classifying front end and the
// output back end.
//------------------------------------------------------------------------------
// Path: a token that an accepted character completes is written into the queue and
// from there loaded into the output register, which drives the output.
// Throughput: one character per cycle while the queue is not full; a character that
// completes two tokens sends them as separate output transfers, and the four-entry queue absorbs such bursts.
// Reset: asynchronous, active low; clears the lexer state, queue and output.
module keyword_lexer #(
	parameter int POSITION_BITS = klex_pkg::POSITION_BITS_DEF,
	parameter int KEYWORD_CHARS = klex_pkg::KEYWORD_CHARS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [klex_pkg::TDATA_IN_W-1:0]      s_tdata,   // [7:0] char_byte
	input  logic [0:0]                           s_tuser,   // [0] end_of_text
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [klex_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [5:0] kind, [37:6] start, [53:38] length
	output logic                                 m_tlast    // last_of_run
);

	logic             full;
	logic             push;
	logic             pop;
	logic             empty;
	klex_pkg::entry_t push_entry;
	klex_pkg::entry_t head;

	klex_front #(
		.POSITION_BITS (POSITION_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.full       (full),
		.push       (push),
		.push_entry (push_entry)
	);

	klex_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	klex_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
